// File: design/ilir_pkg.sv
// Package for the indexed list insert/remove unit.
// Holds request and result types, operation and status codes, and the cell command.
// No dependencies.
`default_nettype none

package ilir_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_PEEK   = 2'd1,
    OP_POP    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SH_HOLD   = 2'd0,
    SH_INSERT = 2'd1,
    SH_REMOVE = 2'd2
  } shift_e;

  typedef struct packed {
    op_e         op;
    logic [4:0]  position;
    logic [31:0] data_in;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] data_out;
    logic [4:0]  count;
  } rsp_t;

  // Broadcast to every cell: what to do this cycle and where.
  typedef struct packed {
    shift_e     shift;
    logic [4:0] pos;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: design/ilir_cell.sv
// One storage cell of the list: holds the entry at a fixed position.
// Takes the new word or its left neighbor on insert and its right neighbor on remove.
// Depends on ilir_pkg.
`default_nettype none

module ilir_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int INDEX      = 0
) (
  input  wire logic                    clk_i,
  input  wire ilir_pkg::cell_cmd_t     cmd_i,
  input  wire logic [DATA_WIDTH-1:0]   word_i,
  input  wire logic [DATA_WIDTH-1:0]   prev_i,
  input  wire logic [DATA_WIDTH-1:0]   next_i,
  output logic [DATA_WIDTH-1:0]        q_o
);

  // Positions are five bits wide, so cells past 31 always lie behind the target.
  localparam bit Beyond = (INDEX > 31);

  logic                  at_pos;
  logic                  behind;
  logic [DATA_WIDTH-1:0] q_d;
  logic [DATA_WIDTH-1:0] q_q;

  assign at_pos = !Beyond && (cmd_i.pos == 5'(INDEX));
  assign behind = Beyond || (cmd_i.pos < 5'(INDEX));

  always_comb begin
    q_d = q_q;
    unique case (cmd_i.shift)
      ilir_pkg::SH_INSERT: begin
        if (at_pos) begin
          q_d = word_i;
        end else if (behind) begin
          q_d = prev_i;
        end
      end
      ilir_pkg::SH_REMOVE: begin
        if (at_pos || behind) begin
          q_d = next_i;
        end
      end
      default: begin
        q_d = q_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign q_o = q_q;

endmodule

`default_nettype wire

// File: design/ilir_ctrl.sv
// Request decoder, entry counter and result register of the list unit.
// Drives the shift command that all cells see. Depends on ilir_pkg.
`default_nettype none

module ilir_ctrl #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire ilir_pkg::req_t        in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output ilir_pkg::rsp_t             out_data_o,
  input  wire logic [DATA_WIDTH-1:0] rd_word_i,
  output ilir_pkg::cell_cmd_t        cmd_o,
  output logic [DATA_WIDTH-1:0]      word_o
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int CmpW = (CntW > 5) ? CntW : 5;

  logic            accept;
  logic [CntW-1:0] count_d, count_q;
  logic            out_valid_d, out_valid_q;
  ilir_pkg::rsp_t  out_data_d, out_data_q;
  logic [CmpW-1:0] pos_ext;
  logic [CmpW-1:0] cnt_ext;
  ilir_pkg::shift_e shift;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pos_ext    = CmpW'(in_data_i.position);
  assign cnt_ext    = CmpW'(count_q);

  always_comb begin
    shift               = ilir_pkg::SH_HOLD;
    count_d             = count_q;
    out_data_d.status   = ilir_pkg::ST_BAD_INDEX;
    out_data_d.data_out = '0;
    unique case (in_data_i.op)
      ilir_pkg::OP_INSERT: begin
        if (pos_ext > cnt_ext) begin
          out_data_d.status = ilir_pkg::ST_BAD_INDEX;
        end else if (cnt_ext == CmpW'(CAPACITY)) begin
          out_data_d.status = ilir_pkg::ST_FULL;
        end else begin
          out_data_d.status = ilir_pkg::ST_OK;
          shift             = ilir_pkg::SH_INSERT;
          count_d           = count_q + 1'b1;
        end
      end
      ilir_pkg::OP_PEEK, ilir_pkg::OP_POP: begin
        if (pos_ext < cnt_ext) begin
          out_data_d.status   = ilir_pkg::ST_OK;
          out_data_d.data_out = 32'(rd_word_i);
          if (in_data_i.op == ilir_pkg::OP_POP) begin
            shift   = ilir_pkg::SH_REMOVE;
            count_d = count_q - 1'b1;
          end
        end
      end
      default: begin
        out_data_d.status = ilir_pkg::ST_BAD_INDEX;
      end
    endcase
    out_data_d.count = 5'(count_d);
    if (!accept) begin
      shift   = ilir_pkg::SH_HOLD;
      count_d = count_q;
    end
  end

  assign out_valid_d = accept || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign cmd_o.shift = shift;
  assign cmd_o.pos   = in_data_i.position;
  assign word_o      = DATA_WIDTH'(in_data_i.data_in);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_shift_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (shift != ilir_pkg::SH_HOLD) |-> accept)
    else $error("cells shifted without a transfer");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted request left no result");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && out_data_d.status == ilir_pkg::ST_FULL) |-> count_q == CntW'(CAPACITY))
    else $error("full status while store has room");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && shift == ilir_pkg::SH_INSERT) |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the count by one");
`endif

endmodule

`default_nettype wire

// File: design/indexed_list_insert_remove_unit.sv
// Indexed list insert/remove unit: top level with the row of cells and read select.
// Depends on ilir_pkg, ilir_cell and ilir_ctrl.
`default_nettype none

// Keeps an ordered list of up to CAPACITY words, one per cell in a row of
// CAPACITY cells. Requests are insert, peek or pop at a position; on an insert
// or pop all cells behind the position shift by one place at once, so a new
// request can be taken in every cycle in which the result register is empty
// or its result is being transferred. Each request returns exactly one result
// with status, data and the count after the request; the result register is
// freed in the same cycle it is taken. Words are kept to their low DATA_WIDTH
// bits. No clearing pass is needed after reset.
module indexed_list_insert_remove_unit #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire ilir_pkg::req_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ilir_pkg::rsp_t      out_data_o
);

  // Only the first 32 cells can be addressed by a five-bit position.
  localparam int NumRead = (CAPACITY < 32) ? CAPACITY : 32;

  ilir_pkg::cell_cmd_t   cmd;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] rd_word;
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

  ilir_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .rd_word_i   (rd_word),
    .cmd_o       (cmd),
    .word_o      (word)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev;
    logic [DATA_WIDTH-1:0] next;

    if (g == 0) begin : g_first
      assign prev = '0;
    end else begin : g_mid_prev
      assign prev = cell_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign next = cell_q[g];
    end else begin : g_mid_next
      assign next = cell_q[g+1];
    end

    ilir_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (g)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .word_i (word),
      .prev_i (prev),
      .next_i (next),
      .q_o    (cell_q[g])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int k = 0; k < NumRead; k++) begin
      if (in_data_i.position == 5'(k)) begin
        rd_word = cell_q[k];
      end
    end
  end

endmodule

`default_nettype wire

// File: tb/tb_indexed_list_insert_remove_unit.sv
// Self-checking testbench for indexed_list_insert_remove_unit.
// Drives a directed table and then random requests, checking each result against the table or a list model.
// Depends on ilir_pkg and the design top level; needs no files at run time.
`timescale 1ns / 1ps

module tb_indexed_list_insert_remove_unit;
  import ilir_pkg::*;

  localparam int CAPACITY       = 16;
  localparam int DATA_WIDTH     = 32;
  localparam int RANDOM_ITEMS   = 500;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_AFTER = 150;
  localparam int HOLD_OFF_LEN   = 80;
  localparam int TAIL_CYCLES    = 4;
  // The op field has one code that the package leaves unnamed.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } step_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_data_o;

  logic [31:0] list_words[$];
  rsp_t        awaited_results[$];
  step_row_t   directed_steps[$];

  int error_count     = 0;
  int requests_taken  = 0;
  int results_checked = 0;
  int full_seen       = 0;
  int bad_index_seen  = 0;
  int peak_fill       = 0;
  int burst_left      = 0;

  indexed_list_insert_remove_unit #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Applies one request to the list model and returns the result it yields.
  function automatic rsp_t list_result(input req_t r);
    rsp_t res;
    res.status   = ST_BAD_INDEX;
    res.data_out = '0;
    case (r.op)
      OP_INSERT: begin
        if (r.position <= list_words.size()) begin
          if (list_words.size() >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            list_words.insert(r.position, r.data_in);
            res.status = ST_OK;
          end
        end
      end
      OP_PEEK, OP_POP: begin
        if (r.position < list_words.size()) begin
          res.data_out = list_words[r.position];
          res.status   = ST_OK;
          if (r.op == OP_POP) begin
            list_words.delete(r.position);
          end
        end
      end
      default: ;
    endcase
    res.count = 5'(list_words.size());
    return res;
  endfunction

  function automatic void add_step(input op_e op, input int pos, input logic [31:0] data,
                                   input bit typed, input status_e st = ST_OK,
                                   input logic [31:0] dout = '0, input int cnt = 0);
    step_row_t row;
    row.req.op          = op;
    row.req.position    = 5'(pos);
    row.req.data_in     = data;
    row.typed           = typed;
    row.want.status     = st;
    row.want.data_out   = dout;
    row.want.count      = 5'(cnt);
    directed_steps.push_back(row);
  endfunction

  // Filling mode favors inserts, draining mode favors pops; most positions are in range.
  function automatic req_t random_request(input bit filling);
    req_t r;
    int   n;
    int   pick;
    n         = list_words.size();
    pick      = $urandom_range(0, 99);
    r.data_in = $urandom();
    if (pick < 4) begin
      r.op = op_e'(OP_UNUSED);
    end else if (pick < 24) begin
      r.op = OP_PEEK;
    end else if ((pick < 74) == filling) begin
      r.op = OP_INSERT;
    end else begin
      r.op = OP_POP;
    end
    if ($urandom_range(0, 9) == 0 || (n == 0 && r.op != OP_INSERT)) begin
      r.position = 5'($urandom_range(0, 31));
    end else if (r.op == OP_INSERT) begin
      r.position = 5'($urandom_range(0, n));
    end else begin
      r.position = 5'($urandom_range(0, n - 1));
    end
    return r;
  endfunction

  // Offers one request, with a random gap between bursts, and records the expected
  // result once the transfer has happened.
  task automatic issue_request(input req_t r, input bit typed, input rsp_t want);
    rsp_t predicted;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 50 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = list_result(r);
    awaited_results.push_back(typed ? want : predicted);
    requests_taken++;
    if (list_words.size() > peak_fill) begin
      peak_fill = list_words.size();
    end
  endtask

  // Receiver: changes its stall pattern now and then, and once holds off for a long stretch.
  initial begin
    int  mode;
    int  mode_left;
    bit  hold_done;
    mode        = 0;
    mode_left   = 30;
    hold_done   = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && requests_taken >= HOLD_OFF_AFTER) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
        mode_left--;
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 60);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        $error("result transfer with no request waiting: status %0d data %h count %0d",
               out_data_o.status, out_data_o.data_out, out_data_o.count);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (want.status == ST_FULL) full_seen++;
        if (want.status == ST_BAD_INDEX) bad_index_seen++;
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data_o.status);
          error_count++;
        end
        if (out_data_o.data_out !== want.data_out) begin
          $error("data_out: expected %h, actual %h", want.data_out, out_data_o.data_out);
          error_count++;
        end
        if (out_data_o.count !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, out_data_o.count);
          error_count++;
        end
      end
    end
  end

  // Ends the run when no transfer happens on either side for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb_indexed_list_insert_remove_unit NOT OK");
    $finish;
  end

  initial begin
    rsp_t none;
    bit   filling;
    int   mode_left;
    none       = '0;
    filling    = 1'b1;
    mode_left  = 30;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;

    // Errors on an empty list, including the unused op code, then the first inserts and a peek.
    add_step(OP_PEEK, 0, 32'h0, 1'b1, ST_BAD_INDEX, 32'h0, 0);
    add_step(OP_POP, 31, 32'h0, 1'b1, ST_BAD_INDEX, 32'h0, 0);
    add_step(OP_INSERT, 1, 32'h1234_5678, 1'b1, ST_BAD_INDEX, 32'h0, 0);
    add_step(op_e'(OP_UNUSED), 0, 32'hFFFF_FFFF, 1'b1, ST_BAD_INDEX, 32'h0, 0);
    add_step(OP_INSERT, 0, 32'hFFFF_FFFF, 1'b1, ST_OK, 32'h0, 1);
    add_step(OP_PEEK, 0, 32'h0, 1'b1, ST_OK, 32'hFFFF_FFFF, 1);
    add_step(OP_INSERT, 1, 32'h0, 1'b1, ST_OK, 32'h0, 2);
    // Fill to capacity at scattered positions: front, middle and end.
    for (int i = 2; i < CAPACITY; i++) begin
      add_step(OP_INSERT, (i * 7) % (i + 1), $urandom(), 1'b0);
    end
    // Full list: a valid position reports full, a position past the end reports a bad index.
    add_step(OP_INSERT, 16, 32'hA5A5_A5A5, 1'b1, ST_FULL, 32'h0, 16);
    add_step(OP_INSERT, 31, 32'h5A5A_5A5A, 1'b1, ST_BAD_INDEX, 32'h0, 16);
    add_step(OP_PEEK, 16, 32'h0, 1'b1, ST_BAD_INDEX, 32'h0, 16);
    add_step(OP_POP, 15, 32'h0, 1'b0);
    add_step(OP_POP, 0, 32'h0, 1'b0);
    add_step(OP_PEEK, 7, 32'h0, 1'b0);
    add_step(op_e'(OP_UNUSED), 31, 32'hFFFF_FFFF, 1'b1, ST_BAD_INDEX, 32'h0, 14);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_steps[i]) begin
      issue_request(directed_steps[i].req, directed_steps[i].typed, directed_steps[i].want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      issue_request(random_request(filling), 1'b0, none);
      mode_left--;
      if (mode_left == 0) begin
        filling   = ~filling;
        mode_left = $urandom_range(20, 60);
      end
    end
    in_valid_i <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Checked %0d results for %0d requests; peak fill %0d of %0d entries.",
             results_checked, requests_taken, peak_fill, CAPACITY);
    $display("Results with a full list: %0d, with a bad index or unused op: %0d.",
             full_seen, bad_index_seen);
    if (error_count == 0) begin
      $display("tb_indexed_list_insert_remove_unit OK");
    end else begin
      $display("tb_indexed_list_insert_remove_unit NOT OK");
    end
    $finish;
  end

endmodule
